@@ src/srv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srv_pkg
// Shared types and constants of the multiplexed servo pulse controller.
// ----------------------------------------------------------------------------
`default_nettype none

package srv_pkg;

	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS = 2'd2;

	localparam logic [15:0] RST_MIN_WIDTH = 16'd12000;
	localparam logic [15:0] RST_MAX_WIDTH = 16'd48000;
	localparam logic [7:0]  RST_GAP_TICKS = 8'd20;
	localparam logic [15:0] RST_WIDTH     = 16'd30000;

	// result kinds
	localparam logic [2:0] KIND_TIMING    = 3'd0;
	localparam logic [2:0] KIND_REPORT    = 3'd1;
	localparam logic [2:0] KIND_BAD_VALUE = 3'd2;
	localparam logic [2:0] KIND_BAD_INDEX = 3'd3;
	localparam logic [2:0] KIND_SYNTAX    = 3'd4;

	localparam logic [7:0] CHR_CR = 8'd13;
	localparam logic [7:0] CHR_LF = 8'd10;
	localparam logic [7:0] CHR_R  = 8'h52;
	localparam logic [7:0] CHR_S  = 8'h53;

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  channel_select;
		logic        pulse_active;
		logic [7:0]  report_index;
		logic [15:0] report_value;
		logic        last;
	} out_t;

	// state of the line parser as seen by the controller
	typedef struct packed {
		logic        eol;
		logic        empty;
		logic [7:0]  cmd;
		logic        has_value;
		logic [7:0]  index;
		logic [15:0] value;
	} srv_line_t;

endpackage

`default_nettype wire

@@ src/srv_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srv_table
// Pulse width memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module srv_table #(
	parameter int CHANNELS = 16,
	parameter int ADDR_W = $clog2(CHANNELS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [15:0]       rdata,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [15:0]       wdata
);

	logic [15:0]         mem [CHANNELS];
	logic [CHANNELS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// entries never written read as the reset width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rdata   <= srv_pkg::RST_WIDTH;
		end else begin
			if (re) begin
				rdata <= valid_q[raddr] ? mem[raddr] : srv_pkg::RST_WIDTH;
			end
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/srv_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srv_parser
// Upper-cases received bytes and parses command lines on the fly.
// ----------------------------------------------------------------------------
`default_nettype none

module srv_parser #(
	parameter int LINE_LIMIT = 64,
	parameter int POS_W = $clog2(LINE_LIMIT)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        rx_byte,
	output srv_pkg::srv_line_t     line
);

	typedef enum logic [2:0] {
		PH_FIND_INDEX,
		PH_IN_INDEX,
		PH_FIND_VALUE,
		PH_IN_VALUE,
		PH_DONE
	} phase_t;

	phase_t           phase_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       cmd_q;
	logic [7:0]       idx_q;
	logic [15:0]      val_q;
	logic [7:0]       c;
	logic [7:0]       d;
	logic             digit;
	logic             eol;

	always_comb begin
		c = rx_byte;
		if (rx_byte >= 8'h61 && rx_byte <= 8'h7A) begin
			c = rx_byte - 8'd32;
		end
		eol   = (c == srv_pkg::CHR_CR) || (c == srv_pkg::CHR_LF);
		digit = (c >= 8'h30) && (c <= 8'h39);
		d     = c - 8'h30;
	end

	assign line.eol       = eol;
	assign line.empty     = (pos_q == '0);
	assign line.cmd       = cmd_q;
	assign line.has_value = (phase_q == PH_IN_VALUE) || (phase_q == PH_DONE);
	assign line.index     = idx_q;
	assign line.value     = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIND_INDEX;
			pos_q   <= '0;
			cmd_q   <= '0;
			idx_q   <= '0;
			val_q   <= '0;
		end else if (step) begin
			if (eol) begin
				phase_q <= PH_FIND_INDEX;
				pos_q   <= '0;
				idx_q   <= '0;
				val_q   <= '0;
			end else if (pos_q < POS_W'(LINE_LIMIT - 1)) begin
				pos_q <= pos_q + POS_W'(1);
				if (pos_q == '0) begin
					cmd_q <= c;
				end else begin
					unique case (phase_q)
						PH_FIND_INDEX: begin
							if (digit) begin
								phase_q <= PH_IN_INDEX;
								idx_q   <= d;
							end
						end
						PH_IN_INDEX: begin
							// times ten as shift and add, wraps mod 256
							if (digit) idx_q <= (idx_q << 3) + (idx_q << 1) + d;
							else phase_q <= PH_FIND_VALUE;
						end
						PH_FIND_VALUE: begin
							if (digit) begin
								phase_q <= PH_IN_VALUE;
								val_q   <= 16'(d);
							end
						end
						PH_IN_VALUE: begin
							if (digit) val_q <= (val_q << 3) + (val_q << 1) + 16'(d);
							else phase_q <= PH_DONE;
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ src/multiplexed_servo_pulse_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiplexed_servo_pulse_controller
// Servo pulse timing for a multiplexed pulse line with a serial command parser.
// ----------------------------------------------------------------------------
// Input transfers carry either a timer tick (mode 0) or a received byte
// (mode 1). A tick gives one timing result showing channel and pulse state
// before the count advances. Bytes build lines; CR or LF ends a line: "R"
// reports every width, "S idx value" stores a width or reports an error.
// A tick that ends a slot holds off input while the next channel's width is
// read from the table memory, a registered read, and loaded. A byte keeps
// the controller idle; an "R" line end holds off input while it does one
// table read and one output load per report entry. Timing and error results
// appear in the output register in the cycle after the transfer; the first
// report entry follows the RD and EMIT states. A new input is taken while the
// controller is idle and the output register is empty or is being emptied in
// the same cycle; when the receiver stalls, input stalls too.
// Reset sets the table to 30000 ticks for every channel, channel 0, count 0
// and the default limits; configuration writes take effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module multiplexed_servo_pulse_controller #(
	parameter int CHANNELS = 16,
	parameter int LINE_LIMIT = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire srv_pkg::in_t                      in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output srv_pkg::out_t                          out_data,
	input  wire logic                              cfg_we,
	input  wire logic [srv_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [srv_pkg::CFG_W-1:0]         cfg_data
);

	localparam int CH_W = $clog2(CHANNELS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RD,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [15:0]        min_q;
	logic [15:0]        max_q;
	logic [7:0]         gap_q;
	logic [CH_W-1:0]    ch_q;
	logic [16:0]        count_q;
	logic [15:0]        width_q;
	logic [CH_W-1:0]    rep_q;
	logic               out_valid_q;
	srv_pkg::out_t      out_q;

	srv_pkg::srv_line_t line;
	srv_pkg::out_t      base;
	logic               in_fire;
	logic               out_free;
	logic               pulse;
	logic [16:0]        slot_len;
	logic [16:0]        next_count;
	logic               wrap;
	logic [CH_W-1:0]    next_ch;
	logic               idx_ok;
	logic               val_ok;
	logic               table_we;
	logic               table_re;
	logic [CH_W-1:0]    raddr;
	logic [15:0]        rdata;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign in_fire  = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		pulse      = count_q < 17'(width_q);
		slot_len   = 17'(width_q) + 17'(gap_q) + 17'd1;
		next_count = count_q + 17'd1;
		wrap       = next_count >= slot_len;
		next_ch    = (ch_q == CH_W'(CHANNELS - 1)) ? '0 : ch_q + CH_W'(1);
		idx_ok     = line.index < 8'(CHANNELS);
		val_ok     = (line.value >= min_q) && (line.value < max_q);
		table_we   = in_fire && in_data.mode && line.eol && !line.empty
			&& (line.cmd == srv_pkg::CHR_S) && line.has_value && idx_ok && val_ok;
		table_re   = (in_fire && !in_data.mode && wrap) || (state_q == ST_RD);
		raddr      = (state_q == ST_RD) ? rep_q : next_ch;

		base                = '0;
		base.channel_select = 4'(ch_q);
		base.pulse_active   = pulse;
		base.last           = 1'b1;
	end

	srv_parser #(
		.LINE_LIMIT(LINE_LIMIT)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (in_fire && in_data.mode),
		.rx_byte(in_data.rx_byte),
		.line   (line)
	);

	srv_table #(
		.CHANNELS(CHANNELS)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.re    (table_re),
		.raddr (raddr),
		.rdata (rdata),
		.we    (table_we),
		.waddr (line.index[CH_W-1:0]),
		.wdata (line.value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= srv_pkg::RST_MIN_WIDTH;
			max_q <= srv_pkg::RST_MAX_WIDTH;
			gap_q <= srv_pkg::RST_GAP_TICKS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				srv_pkg::REG_MIN_WIDTH: min_q <= cfg_data;
				srv_pkg::REG_MAX_WIDTH: max_q <= cfg_data;
				srv_pkg::REG_GAP_TICKS: gap_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			count_q     <= '0;
			width_q     <= srv_pkg::RST_WIDTH;
			rep_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (!in_data.mode) begin
							out_q       <= base;
							out_q.kind  <= srv_pkg::KIND_TIMING;
							out_valid_q <= 1'b1;
							if (wrap) begin
								// table read of the next channel is in flight
								count_q <= '0;
								ch_q    <= next_ch;
								state_q <= ST_LOAD;
							end else begin
								count_q <= next_count;
							end
						end else if (line.eol && !line.empty) begin
							if (line.cmd == srv_pkg::CHR_R) begin
								rep_q   <= '0;
								state_q <= ST_RD;
							end else if (line.cmd == srv_pkg::CHR_S) begin
								if (!line.has_value) begin
									out_q       <= base;
									out_q.kind  <= srv_pkg::KIND_SYNTAX;
									out_valid_q <= 1'b1;
								end else if (!idx_ok) begin
									out_q              <= base;
									out_q.kind         <= srv_pkg::KIND_BAD_INDEX;
									out_q.report_index <= line.index;
									out_q.report_value <= line.value;
									out_valid_q        <= 1'b1;
								end else if (!val_ok) begin
									out_q              <= base;
									out_q.kind         <= srv_pkg::KIND_BAD_VALUE;
									out_q.report_index <= line.index;
									out_q.report_value <= line.value;
									out_valid_q        <= 1'b1;
								end
							end
						end
					end
				end
				ST_LOAD: begin
					width_q <= rdata;
					state_q <= ST_IDLE;
				end
				ST_RD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_q              <= base;
						out_q.kind         <= srv_pkg::KIND_REPORT;
						out_q.report_index <= 8'(rep_q);
						out_q.report_value <= rdata;
						out_q.last         <= (rep_q == CH_W'(CHANNELS - 1));
						out_valid_q        <= 1'b1;
						if (rep_q == CH_W'(CHANNELS - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							rep_q   <= rep_q + CH_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
